// ----- rtl/core/spc_pkg.sv -----
// shared types and constants for the segment plane clipper
package spc_pkg;

  localparam int unsigned DistW = 64;
  localparam int unsigned RatioW = 33;
  localparam int unsigned DivSteps = 33;

  typedef enum logic [1:0] {
    CLASS_BACK  = 2'd0,
    CLASS_FRONT = 2'd1,
    CLASS_CLIP  = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vec4_t;

  // one segment in flight together with its classification
  typedef struct packed {
    vec4_t  a;
    vec4_t  b;
    class_t cls;
    logic   a_neg;
  } seg_t;

endpackage

// ----- rtl/core/segment_plane_clipper.sv -----
// top level of the segment plane clipper
//   channel | ports                           | beat
//   input   | in_valid/in_ready, in_pos_*     | one segment
//   output  | out_valid/out_ready, out_*      | class and two endpoints
//   config  | psel..pready                    | one register write
// the pipeline is 2 distance stages, 1 divider input register, 33 divider
// stages, 2 interpolation stages and the output register; one segment
// per cycle sustained while the output is not stalled, set by the divider
// pipeline (one quotient bit per stage)
// a stall freezes the whole pipeline; the output register holds its beat
// and in_ready follows out_ready or an empty output slot
// reset clears valid bits and loads the reset plane
module segment_plane_clipper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pos_a_x, input logic [31:0] in_pos_a_y,
  input  logic [31:0] in_pos_a_z, input logic [31:0] in_pos_a_w,
  input  logic [31:0] in_pos_b_x, input logic [31:0] in_pos_b_y,
  input  logic [31:0] in_pos_b_z, input logic [31:0] in_pos_b_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_class,
  output logic [31:0] out_out_a_x, output logic [31:0] out_out_a_y,
  output logic [31:0] out_out_a_z, output logic [31:0] out_out_a_w,
  output logic [31:0] out_out_b_x, output logic [31:0] out_out_b_y,
  output logic [31:0] out_out_b_z, output logic [31:0] out_out_b_w,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Lat = 2 + 1 + spc_pkg::DivSteps + 2;

  spc_pkg::plane_t plane_r;
  logic [1:0] ridx;
  assign ridx = paddr[3:2];
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '{nx: '0, ny: 32'sh40000000, nz: '0, d: '0};
    end else if (psel && penable && pwrite) begin
      unique case (spc_pkg::reg_idx_t'(ridx))
        spc_pkg::REG_NORMAL_X:     plane_r.nx <= pwdata;
        spc_pkg::REG_NORMAL_Y:     plane_r.ny <= pwdata;
        spc_pkg::REG_NORMAL_Z:     plane_r.nz <= pwdata;
        spc_pkg::REG_PLANE_OFFSET: plane_r.d  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (spc_pkg::reg_idx_t'(ridx))
      spc_pkg::REG_NORMAL_X:     prdata = plane_r.nx;
      spc_pkg::REG_NORMAL_Y:     prdata = plane_r.ny;
      spc_pkg::REG_NORMAL_Z:     prdata = plane_r.nz;
      spc_pkg::REG_PLANE_OFFSET: prdata = plane_r.d;
      default:                   prdata = '0;
    endcase
  end

  // global pipeline enable: advance unless the output slot is full and stalled
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  spc_pkg::vec4_t pa, pb;
  assign pa = '{x: in_pos_a_x, y: in_pos_a_y, z: in_pos_a_z, w: in_pos_a_w};
  assign pb = '{x: in_pos_b_x, y: in_pos_b_y, z: in_pos_b_z, w: in_pos_b_w};

  // valid bits and segment payload travel along the full latency
  logic            vld_r [Lat];
  spc_pkg::seg_t   seg_r [Lat];

  logic signed [63:0] sa, sb, den;
  logic [63:0] num_mag, den_mag;
  logic [spc_pkg::RatioW-1:0] t;

  spc_dist u_dist_a (.clk, .en(adv), .plane(plane_r), .p(pa), .sdist(sa));
  spc_dist u_dist_b (.clk, .en(adv), .plane(plane_r), .p(pb), .sdist(sb));

  // classify at the stage where both distances arrive
  spc_pkg::class_t cls;
  always_comb begin
    priority if (sa[63] && sb[63]) cls = spc_pkg::CLASS_BACK;
    else if (!sa[63] && !sb[63])   cls = spc_pkg::CLASS_FRONT;
    else                           cls = spc_pkg::CLASS_CLIP;
  end

  logic [63:0] num_r, den_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_mag;
      den_r <= den_mag;
    end
  end
  assign den     = sa - sb;
  assign num_mag = sa[63] ? 64'(-sa) : 64'(sa);
  assign den_mag = den[63] ? 64'(-den) : 64'(den);

  spc_div u_div (.clk, .en(adv), .num(num_r), .den(den_r), .quo(t));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < Lat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg_r[0].a <= pa;
      seg_r[0].b <= pb;
      seg_r[0].cls <= spc_pkg::CLASS_FRONT;
      seg_r[0].a_neg <= 1'b0;
      seg_r[1] <= seg_r[0];
      // distances valid for seg_r[1]; tag it on the way to stage 2
      seg_r[2].a <= seg_r[1].a;
      seg_r[2].b <= seg_r[1].b;
      seg_r[2].cls <= cls;
      seg_r[2].a_neg <= sa[63];
      for (int i = 3; i < Lat; i++) seg_r[i] <= seg_r[i-1];
    end
  end

  // interpolation inputs come from the stage aligned with the quotient
  localparam int unsigned Ls = 2 + spc_pkg::DivSteps;
  spc_pkg::vec4_t lr;
  spc_lerp u_lx (.clk, .en(adv), .a(seg_r[Ls].a.x), .b(seg_r[Ls].b.x), .t, .res(lr.x));
  spc_lerp u_ly (.clk, .en(adv), .a(seg_r[Ls].a.y), .b(seg_r[Ls].b.y), .t, .res(lr.y));
  spc_lerp u_lz (.clk, .en(adv), .a(seg_r[Ls].a.z), .b(seg_r[Ls].b.z), .t, .res(lr.z));
  spc_lerp u_lw (.clk, .en(adv), .a(seg_r[Ls].a.w), .b(seg_r[Ls].b.w), .t, .res(lr.w));

  // output register
  logic          ov_r;
  spc_pkg::seg_t os_r;
  spc_pkg::seg_t fin;
  always_comb begin
    fin = seg_r[Lat-1];
    if (fin.cls == spc_pkg::CLASS_CLIP) begin
      if (fin.a_neg) fin.a = lr;
      else           fin.b = lr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= vld_r[Lat-1];
  end
  always_ff @(posedge clk) begin
    if (adv) os_r <= fin;
  end

  assign out_valid = ov_r;
  assign out_result_class = os_r.cls;
  assign out_out_a_x = os_r.a.x;
  assign out_out_a_y = os_r.a.y;
  assign out_out_a_z = os_r.a.z;
  assign out_out_a_w = os_r.a.w;
  assign out_out_b_x = os_r.b.x;
  assign out_out_b_y = os_r.b.y;
  assign out_out_b_z = os_r.b.z;
  assign out_out_b_w = os_r.b.w;

endmodule

// ----- rtl/core/spc_dist.sv -----
// plane distance of one endpoint, two pipeline stages
module spc_dist (
  input  logic                             clk,
  input  logic                             en,
  input  spc_pkg::plane_t                  plane,
  input  spc_pkg::vec4_t                   p,
  output logic signed [spc_pkg::DistW-1:0] sdist
);

  logic signed [63:0] px_r, py_r, pz_r, po_r;
  logic signed [63:0] dist_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= (64'(plane.nx) * 64'(p.x)) >>> 2;
      py_r   <= (64'(plane.ny) * 64'(p.y)) >>> 2;
      pz_r   <= (64'(plane.nz) * 64'(p.z)) >>> 2;
      po_r   <= 64'(plane.d) <<< 28;
      dist_r <= px_r + py_r + pz_r + po_r;
    end
  end

  assign sdist = dist_r;

endmodule

// ----- rtl/core/spc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module spc_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [spc_pkg::DistW-1:0]         num,
  input  logic [spc_pkg::DistW-1:0]         den,
  output logic [spc_pkg::RatioW-1:0]        quo
);

  localparam int unsigned N = spc_pkg::DivSteps;

  logic [spc_pkg::DistW:0]        rem_r [N];
  logic [spc_pkg::DistW-1:0]      den_r [N];
  logic [spc_pkg::RatioW-1:0]     q_r   [N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        logic [spc_pkg::DistW:0]    r;
        logic [spc_pkg::DistW-1:0]  dv;
        logic [spc_pkg::RatioW-1:0] q;
        if (i == 0) begin
          r  = {1'b0, num};
          dv = den;
          q  = '0;
        end else begin
          r  = rem_r[i-1] << 1;
          dv = den_r[i-1];
          q  = q_r[i-1] << 1;
        end
        if (dv != '0 && r >= {1'b0, dv}) begin
          r = r - {1'b0, dv};
          q[0] = 1'b1;
        end
        if (dv == '0) q = '0;
        rem_r[i] <= r;
        den_r[i] <= dv;
        q_r[i]   <= q;
      end
    end
  end

  assign quo = q_r[N-1];

endmodule

// ----- rtl/core/spc_lerp.sv -----
// interpolation of one component, two pipeline stages
module spc_lerp (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          a,
  input  logic signed [31:0]          b,
  input  logic [spc_pkg::RatioW-1:0]  t,
  output logic signed [31:0]          res
);

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [65:0]        prod_r;
  logic               neg_r;
  logic signed [31:0] a_r;
  logic [33:0]        off;
  logic signed [34:0] sum;
  logic signed [31:0] res_r;

  assign diff = 33'(b) - 33'(a);
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 66'(mag) * 66'(t);
      neg_r  <= diff[32];
      a_r    <= a;
      res_r  <= sum > 35'sd2147483647 ? 32'sh7fffffff :
                sum < -35'sd2147483648 ? 32'sh80000000 : sum[31:0];
    end
  end

  always_comb begin
    off = 34'((prod_r + 66'h80000000) >> 32);
    sum = neg_r ? 35'(a_r) - $signed({1'b0, off}) : 35'(a_r) + $signed({1'b0, off});
  end

  assign res = res_r;

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the segment plane clipper
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CyclePeriod = 8;
  localparam int unsigned DrainCycles = 60;    // well past the full pipeline
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomPerPhase = 320;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ErrorPrintCap = 50;

  // one segment as it travels on the input channel
  typedef struct packed {
    spc_pkg::vec4_t a;
    spc_pkg::vec4_t b;
  } segment_t;

  // what the clipper should hand back for one segment
  typedef struct packed {
    spc_pkg::class_t cls;
    spc_pkg::vec4_t  a;
    spc_pkg::vec4_t  b;
  } clipped_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  segment_t       in_seg;
  logic           out_valid;
  logic           out_ready;
  logic [1:0]     out_result_class;
  spc_pkg::vec4_t out_a;
  spc_pkg::vec4_t out_b;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [3:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  segment_plane_clipper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_a_x       (in_seg.a.x),
    .in_pos_a_y       (in_seg.a.y),
    .in_pos_a_z       (in_seg.a.z),
    .in_pos_a_w       (in_seg.a.w),
    .in_pos_b_x       (in_seg.b.x),
    .in_pos_b_y       (in_seg.b.y),
    .in_pos_b_z       (in_seg.b.z),
    .in_pos_b_w       (in_seg.b.w),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_class (out_result_class),
    .out_out_a_x      (out_a.x),
    .out_out_a_y      (out_a.y),
    .out_out_a_z      (out_a.z),
    .out_out_a_w      (out_a.w),
    .out_out_b_x      (out_b.x),
    .out_out_b_y      (out_b.y),
    .out_out_b_z      (out_b.z),
    .out_out_b_w      (out_b.w),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock: two delays, 8 ns period
  always begin
    clk = 1'b0;
    #(CyclePeriod / 2);
    clk = 1'b1;
    #(CyclePeriod / 2);
  end

  // shadow copy of the plane registers, tracks every write we issue
  spc_pkg::plane_t plane_shadow;

  segment_t pending_segs[$];    // segments waiting to be driven
  clipped_t expected_clips[$];  // predicted beats waiting on the output

  int unsigned error_count;
  int unsigned seg_count;
  int unsigned beat_count;
  int unsigned class_hits[3];
  int unsigned cycle_count;

  // sender burst shaping and receiver stall pattern, retuned per phase
  logic        sender_no_gaps;
  int unsigned burst_left;
  int unsigned gap_left;
  logic        recv_always_ready;
  logic [15:0] stall_pattern;
  logic [3:0]  stall_idx;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // signed distance in Q.44: each product floored by 4, offset scaled by 2^28
  function automatic longint plane_distance(spc_pkg::plane_t pl, spc_pkg::vec4_t p);
    longint sx, sy, sz;
    sx = (longint'(pl.nx) * longint'(p.x)) >>> 2;
    sy = (longint'(pl.ny) * longint'(p.y)) >>> 2;
    sz = (longint'(pl.nz) * longint'(p.z)) >>> 2;
    return sx + sy + sz + (longint'(pl.d) <<< 28);
  endfunction

  // one component moved toward b by t (Q1.32), rounded half away, saturated
  function automatic logic signed [31:0] lerp_component(logic signed [31:0] a,
                                                        logic signed [31:0] b,
                                                        logic [32:0] t);
    logic signed [35:0] diff;
    logic [35:0]        mag;
    logic [127:0]       prod;
    logic signed [35:0] off;
    logic signed [35:0] v;
    diff = 36'(b) - 36'(a);
    mag  = diff < 0 ? 36'(-diff) : 36'(diff);
    prod = 128'(mag) * 128'(t) + 128'h8000_0000;
    off  = 36'(prod >> 32);
    v    = diff < 0 ? 36'(a) - off : 36'(a) + off;
    if (v > 36'sh0_7FFF_FFFF) v = 36'sh0_7FFF_FFFF;
    if (v < -36'sh0_8000_0000) v = -36'sh0_8000_0000;
    return v[31:0];
  endfunction

  function automatic spc_pkg::vec4_t lerp_point(spc_pkg::vec4_t a, spc_pkg::vec4_t b,
                                                logic [32:0] t);
    spc_pkg::vec4_t r;
    r.x = lerp_component(a.x, b.x, t);
    r.y = lerp_component(a.y, b.y, t);
    r.z = lerp_component(a.z, b.z, t);
    r.w = lerp_component(a.w, b.w, t);
    return r;
  endfunction

  function automatic clipped_t clip_segment(spc_pkg::plane_t pl, segment_t s);
    clipped_t           r;
    longint             da, db;
    logic signed [64:0] span;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [32:0]        t;
    da = plane_distance(pl, s.a);
    db = plane_distance(pl, s.b);
    r.a = s.a;
    r.b = s.b;
    if (da < 0 && db < 0) begin
      r.cls = spc_pkg::CLASS_BACK;
    end else if (da >= 0 && db >= 0) begin
      // a point exactly on the plane counts as front
      r.cls = spc_pkg::CLASS_FRONT;
    end else begin
      r.cls = spc_pkg::CLASS_CLIP;
      span = 65'(da) - 65'(db);
      num  = da < 0 ? 64'(-da) : 64'(da);
      den  = span < 0 ? 64'(-span) : 64'(span);
      t    = den == 0 ? 33'd0 : 33'((128'(num) << 32) / 128'(den));
      // the endpoint behind the plane is pulled onto it
      if (da < 0) r.a = lerp_point(s.a, s.b, t);
      else r.b = lerp_point(s.a, s.b, t);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // input driver: pops pending segments, bursts with random gaps
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_clips.push_back(clip_segment(plane_shadow, in_seg));
        seg_count <= seg_count + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the beat until it is taken
      end else if (gap_left != 0 && !sender_no_gaps) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_segs.size() != 0) begin
        in_seg   <= pending_segs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output monitor: stall pattern on out_ready, compare each beat
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= ErrorPrintCap)
      $error("%s mismatch: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin
    clipped_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_idx <= '0;
    end else begin
      out_ready <= recv_always_ready ? 1'b1 : stall_pattern[stall_idx];
      stall_idx <= stall_idx + 1;
      if (out_valid && out_ready) begin
        beat_count++;
        if (expected_clips.size() == 0) begin
          error_count++;
          $error("output beat with no segment outstanding");
        end else begin
          want = expected_clips.pop_front();
          if (want.cls < 3) class_hits[want.cls]++;
          if (out_result_class != want.cls)
            report_mismatch("result_class", 32'(want.cls), 32'(out_result_class));
          if (out_a.x != want.a.x) report_mismatch("out_a_x", want.a.x, out_a.x);
          if (out_a.y != want.a.y) report_mismatch("out_a_y", want.a.y, out_a.y);
          if (out_a.z != want.a.z) report_mismatch("out_a_z", want.a.z, out_a.z);
          if (out_a.w != want.a.w) report_mismatch("out_a_w", want.a.w, out_a.w);
          if (out_b.x != want.b.x) report_mismatch("out_b_x", want.b.x, out_b.x);
          if (out_b.y != want.b.y) report_mismatch("out_b_y", want.b.y, out_b.y);
          if (out_b.z != want.b.z) report_mismatch("out_b_z", want.b.z, out_b.z);
          if (out_b.w != want.b.w) report_mismatch("out_b_w", want.b.w, out_b.w);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // register access and stimulus
  // ---------------------------------------------------------------------

  // setup cycle then access cycle; register lands at the access edge
  task automatic write_reg(spc_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      spc_pkg::REG_NORMAL_X: plane_shadow.nx = value;
      spc_pkg::REG_NORMAL_Y: plane_shadow.ny = value;
      spc_pkg::REG_NORMAL_Z: plane_shadow.nz = value;
      default:               plane_shadow.d  = value;
    endcase
    // read it back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != value) begin
      error_count++;
      $error("register %s readback: expected %h, got %h", idx.name(), value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] d);
    write_reg(spc_pkg::REG_NORMAL_X, nx);
    write_reg(spc_pkg::REG_NORMAL_Y, ny);
    write_reg(spc_pkg::REG_NORMAL_Z, nz);
    write_reg(spc_pkg::REG_PLANE_OFFSET, d);
  endtask

  function automatic logic [31:0] normal_component();
    return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near_zero();
    return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
  endfunction

  // a mix of random, near-zero, corner-value, short and mirrored segments
  function automatic segment_t random_segment();
    segment_t s;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    s.a = {$urandom, $urandom, $urandom, $urandom};
    s.b = {$urandom, $urandom, $urandom, $urandom};
    case (kind)
      0, 1, 2: begin
        // fully random fields
      end
      3, 4: begin
        s.a = {near_zero(), near_zero(), near_zero(), near_zero()};
        s.b = {near_zero(), near_zero(), near_zero(), near_zero()};
      end
      5: begin
        s.a = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
        s.b = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
      end
      6: begin
        // short segment hugging one point
        s.b.x = s.a.x + near_zero();
        s.b.y = s.a.y + near_zero();
        s.b.z = s.a.z + near_zero();
      end
      default: begin
        // mirrored endpoint, crosses any plane through the origin region
        s.b.x = -s.a.x;
        s.b.y = -s.a.y;
        s.b.z = -s.a.z;
      end
    endcase
    return s;
  endfunction

  // wait for every expected beat, then let the pipeline drain completely
  task automatic wait_idle();
    while (pending_segs.size() != 0 || in_valid || expected_clips.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // the stall pattern always keeps at least one ready slot so the output drains
  task automatic retune_flow(int unsigned phase);
    sender_no_gaps    = (phase % 3) == 1;
    recv_always_ready = (phase % 3) == 2;
    stall_pattern     = 16'($urandom) | 16'h0001;
  endtask

  initial begin
    segment_t s;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_seg            = '0;
    out_ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    error_count       = 0;
    seg_count         = 0;
    beat_count        = 0;
    class_hits        = '{0, 0, 0};
    cycle_count       = 0;
    sender_no_gaps    = 1'b0;
    recv_always_ready = 1'b0;
    stall_pattern     = 16'hA5C3;
    // reset plane is y = 0 with normal +y
    plane_shadow      = '{nx: 32'd0, ny: 32'h4000_0000, nz: 32'd0, d: 32'd0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed segments against the reset plane
    // both ends on the plane: front
    pending_segs.push_back('{a: '{5, 0, 7, 1}, b: '{-5, 0, -7, 2}});
    // one end on the plane, other behind: clip with t of zero or one
    pending_segs.push_back('{a: '{3, 0, 3, 3}, b: '{9, -5, 9, 9}});
    pending_segs.push_back('{a: '{3, -5, 3, 3}, b: '{9, 0, 9, 9}});
    // both behind, both in front
    pending_segs.push_back('{a: '{1, -1, 1, 1}, b: '{2, -1, 2, 2}});
    pending_segs.push_back('{a: '{1, 1, 1, 1}, b: '{2, 1, 2, 2}});
    // plain crossings in both directions
    pending_segs.push_back('{a: '{0, -32'h10000, 0, 32'h10000},
                             b: '{32'h40000, 32'h30000, 0, 32'h20000}});
    pending_segs.push_back('{a: '{32'h40000, 32'h30000, 7, 32'h20000},
                             b: '{0, -32'h10000, -7, 32'h10000}});
    // full-range corners
    pending_segs.push_back('{a: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                             b: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}});
    pending_segs.push_back('{a: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                             b: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}});
    pending_segs.push_back('{a: '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
                             b: '{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF}});
    pending_segs.push_back('{a: '{0, 32'h8000_0000, 0, 0}, b: '{0, 32'h8000_0000, 0, 0}});
    pending_segs.push_back('{a: '{0, 32'h7FFF_FFFF, 0, 0}, b: '{0, 32'h7FFF_FFFF, 0, 0}});
    pending_segs.push_back('{a: '{0, 32'hFFFF_FFFF, 0, 0}, b: '{0, 32'h0000_0001, 0, 0}});
    for (int i = 0; i < 8; i++) pending_segs.push_back(random_segment());
    retune_flow(0);
    wait_idle();

    // plane settings: axis normals, extreme offsets, random planes, then the reset plane again
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_plane(32'h4000_0000, 32'd0, 32'd0, 32'd0);
        1: load_plane(32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'h7FFF_FFFF);
        2: load_plane(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h8000_0000);
        3: load_plane(normal_component(), normal_component(), normal_component(), $urandom);
        4: load_plane(32'($urandom_range(0, 2000)) - 32'd1000, normal_component(),
                      32'd0, near_zero());
        default: load_plane(32'd0, 32'h4000_0000, 32'd0, 32'd0);
      endcase
      retune_flow(phase + 1);
      for (int unsigned i = 0; i < RandomPerPhase; i++) begin
        s = random_segment();
        pending_segs.push_back(s);
      end
      wait_idle();
    end

    $display("%0d segments driven over %0d plane settings, %0d beats checked",
             seg_count, NumPhases + 1, beat_count);
    $display("classes seen: back %0d, front %0d, clipped %0d",
             class_hits[spc_pkg::CLASS_BACK], class_hits[spc_pkg::CLASS_FRONT],
             class_hits[spc_pkg::CLASS_CLIP]);
    if (error_count == 0 && expected_clips.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
